### sv/lbpt_pkg.sv
package lbpt_pkg;

   localparam int STRIP_W      = 4;
   localparam int PIXEL_W      = 6;
   localparam int COLOUR_W     = 8;
   localparam int WORD_W       = 16;
   localparam int STRIPS_CFG_W = 5;
   localparam int PIXELS_CFG_W = 7;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 8;

   localparam int MAX_STRIPS    = 16;
   localparam int MAX_PIXELS    = 64;
   localparam int COLOUR_PLANES = 8;
   localparam int CHANNELS      = 3;
   localparam int STORE_WORDS   = CHANNELS * COLOUR_PLANES;
   localparam int WORD_IDX_W    = $clog2(STORE_WORDS);
   localparam int CHANNEL_W     = 2;
   localparam int PLANE_W       = $clog2(COLOUR_PLANES);

   localparam int QUEUE_DEPTH  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_STRIPS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_PIXELS = CSR_INDEX_W'(1);

   localparam logic [CHANNEL_W-1:0] CH_GREEN = 2'd0;
   localparam logic [CHANNEL_W-1:0] CH_RED   = 2'd1;
   localparam logic [CHANNEL_W-1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic [STRIP_W-1:0]  strip;
      logic [PIXEL_W-1:0]  pixel;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
      logic                emit;
   } lbpt_entry_type;

endpackage

### sv/lbpt_front.sv
module lbpt_front
   import lbpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [STRIP_W-1:0]     req_strip,
   input  logic [PIXEL_W-1:0]     req_pixel,
   input  logic [COLOUR_W-1:0]    req_red,
   input  logic [COLOUR_W-1:0]    req_green,
   input  logic [COLOUR_W-1:0]    req_blue,
   output logic                   push_valid,
   input  logic                   push_ready,
   output lbpt_entry_type         push_entry
);

   localparam logic [STRIPS_CFG_W-1:0] STRIPS_LIMIT = STRIPS_CFG_W'(MAX_STRIPS);
   localparam logic [PIXELS_CFG_W-1:0] PIXELS_LIMIT = PIXELS_CFG_W'(MAX_PIXELS);

   logic [STRIPS_CFG_W-1:0] active_strips_ff, active_strips_in;
   logic [PIXELS_CFG_W-1:0] active_pixels_ff, active_pixels_in;
   logic [STRIPS_CFG_W-1:0] n_strips;
   logic [PIXELS_CFG_W-1:0] n_pixels;
   logic                    keep;

   assign csr_ready = 1'b1;

   always_comb begin
      active_strips_in = active_strips_ff;
      active_pixels_in = active_pixels_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_STRIPS: active_strips_in = csr_data[STRIPS_CFG_W-1:0];
            CSR_ACTIVE_PIXELS: active_pixels_in = csr_data[PIXELS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_strips_ff <= STRIPS_LIMIT;
         active_pixels_ff <= PIXELS_LIMIT;
      end else begin
         active_strips_ff <= active_strips_in;
         active_pixels_ff <= active_pixels_in;
      end
   end

   always_comb begin
      n_strips = (active_strips_ff > STRIPS_LIMIT) ? STRIPS_LIMIT : active_strips_ff;
      n_pixels = (active_pixels_ff > PIXELS_LIMIT) ? PIXELS_LIMIT : active_pixels_ff;
      keep = (STRIPS_CFG_W'(req_strip) < n_strips) && (PIXELS_CFG_W'(req_pixel) < n_pixels);
      push_entry.strip = req_strip;
      push_entry.pixel = req_pixel;
      push_entry.red   = req_red;
      push_entry.green = req_green;
      push_entry.blue  = req_blue;
      push_entry.emit  = (STRIPS_CFG_W'(req_strip) == n_strips - STRIPS_CFG_W'(1));
   end

   // dropped words are taken and discarded
   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;

endmodule

### sv/lbpt_queue.sv
module lbpt_queue
   import lbpt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  lbpt_entry_type push_entry,
   output logic           pop_valid,
   input  logic           pop_ready,
   output lbpt_entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lbpt_entry_type   queue_mem_ff [DEPTH];
   lbpt_entry_type   head_ff;
   logic             head_valid_ff, head_valid_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, refill;

   assign push_ready = (count_ff != CNT_FULL);
   assign push       = push_valid && push_ready;
   assign refill     = (!head_valid_ff || pop_ready) && (count_ff != '0);
   assign pop_valid  = head_valid_ff;
   assign pop_entry  = head_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      head_valid_in = head_valid_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (refill) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !refill) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && refill) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (refill) begin
         head_valid_in = 1'b1;
      end else if (pop_ready) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         head_valid_ff <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (refill) begin
         head_ff <= queue_mem_ff[rd_ptr_ff];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   a_head_fills: assert property (@(posedge clock) disable iff (reset)
      (!head_valid_ff && count_ff != '0) |=> head_valid_ff)
      else $error("queue head not refilled");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

### sv/lbpt_back.sv
module lbpt_back
   import lbpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  lbpt_entry_type        pop_entry,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_W-1:0]    rsp_out_pixel,
   output logic [CHANNEL_W-1:0]  rsp_channel,
   output logic [PLANE_W-1:0]    rsp_plane,
   output logic [WORD_W-1:0]     rsp_plane_word,
   output logic                  rsp_last
);

   localparam logic ST_ACC  = 1'b0;
   localparam logic ST_EMIT = 1'b1;
   localparam logic [WORD_IDX_W-1:0] IDX_LAST = WORD_IDX_W'(STORE_WORDS - 1);

   logic [WORD_W-1:0]     store_ff [STORE_WORDS];
   logic [WORD_W-1:0]     store_in [STORE_WORDS];
   logic [PIXEL_W-1:0]    cur_pixel_ff, cur_pixel_in;
   logic                  state_ff, state_in;
   logic [WORD_IDX_W-1:0] idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]    rsp_pixel_ff;
   logic [CHANNEL_W-1:0]  rsp_channel_ff;
   logic [PLANE_W-1:0]    rsp_plane_ff;
   logic [WORD_W-1:0]     rsp_word_ff;
   logic                  rsp_last_ff;
   logic                  take, load;
   logic [WORD_W-1:0]     strip_bit;
   logic [COLOUR_W-1:0]   colour;
   logic [WORD_W-1:0]     base;

   assign pop_ready = (state_ff == ST_ACC);
   assign take      = pop_valid && pop_ready;
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign strip_bit = WORD_W'(1) << pop_entry.strip;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cur_pixel_in = cur_pixel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      colour       = '0;
      base         = '0;
      for (int k = 0; k < STORE_WORDS; k++) begin
         store_in[k] = store_ff[k];
      end
      if (take) begin
         cur_pixel_in = pop_entry.pixel;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            case (CHANNEL_W'(ch))
               CH_GREEN: colour = pop_entry.green;
               CH_RED:   colour = pop_entry.red;
               CH_BLUE:  colour = pop_entry.blue;
               default:  colour = '0;
            endcase
            for (int p = 0; p < COLOUR_PLANES; p++) begin
               // a new pixel drops whatever partial planes were held
               base = (pop_entry.pixel != cur_pixel_ff) ? '0
                      : store_ff[ch * COLOUR_PLANES + p];
               store_in[ch * COLOUR_PLANES + p] =
                  base | (colour[COLOUR_PLANES - 1 - p] ? strip_bit : '0);
            end
         end
         if (pop_entry.emit) begin
            state_in = ST_EMIT;
            idx_in   = '0;
         end
      end
      if (load) begin
         store_in[idx_ff] = '0;
         rsp_valid_in     = 1'b1;
         idx_in           = idx_ff + WORD_IDX_W'(1);
         if (idx_ff == IDX_LAST) begin
            state_in = ST_ACC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         idx_ff       <= '0;
         cur_pixel_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < STORE_WORDS; k++) begin
            store_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cur_pixel_ff <= cur_pixel_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < STORE_WORDS; k++) begin
            store_ff[k] <= store_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_pixel_ff   <= cur_pixel_ff;
         rsp_channel_ff <= idx_ff[WORD_IDX_W-1:PLANE_W];
         rsp_plane_ff   <= idx_ff[PLANE_W-1:0];
         rsp_word_ff    <= store_ff[idx_ff];
         rsp_last_ff    <= (idx_ff == IDX_LAST);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_pixel  = rsp_pixel_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_plane      = rsp_plane_ff;
   assign rsp_plane_word = rsp_word_ff;
   assign rsp_last       = rsp_last_ff;

   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      (load && idx_ff == IDX_LAST) |=> (state_ff == ST_ACC))
      else $error("emit did not finish after final word");

   a_last_is_blue7: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
      (rsp_channel_ff == CH_BLUE && rsp_plane_ff == PLANE_W'(COLOUR_PLANES - 1)))
      else $error("last flag on wrong word");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (load && !take) |=> (store_ff[$past(idx_ff)] == '0))
      else $error("emitted word not cleared");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_channel_ff <= CH_BLUE))
      else $error("channel code out of range");

endmodule

### sv/led_strip_bit_plane_transpose_unit.sv
// Output path: once the last-strip word is taken, the first plane word passes the queue
// memory, the queue head load, the store update and the output register.
// Flow: one strip word per cycle into the store while it accumulates, then its 24 plane
// words go out under rsp_ready with no strip word taken; the plane store is the shared unit.
// Reset: synchronous, active high; clears the store, pixel, queue and sets
// active_strips to 16 and active_pixels to 64.
module led_strip_bit_plane_transpose_unit
   import lbpt_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [STRIP_W-1:0]     req_strip,
   input  logic [PIXEL_W-1:0]     req_pixel,
   input  logic [COLOUR_W-1:0]    req_red,
   input  logic [COLOUR_W-1:0]    req_green,
   input  logic [COLOUR_W-1:0]    req_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIXEL_W-1:0]     rsp_out_pixel,
   output logic [CHANNEL_W-1:0]   rsp_channel,
   output logic [PLANE_W-1:0]     rsp_plane,
   output logic [WORD_W-1:0]      rsp_plane_word,
   output logic                   rsp_last
);

   logic           push_valid, push_ready;
   lbpt_entry_type push_entry;
   logic           pop_valid, pop_ready;
   lbpt_entry_type pop_entry;

   lbpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_strip  (req_strip),
      .req_pixel  (req_pixel),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   lbpt_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   lbpt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_channel    (rsp_channel),
      .rsp_plane      (rsp_plane),
      .rsp_plane_word (rsp_plane_word),
      .rsp_last       (rsp_last)
   );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import lbpt_pkg::*;
();

   localparam int LIMIT       = 600000;
   localparam int HOLD_AT     = 40;
   localparam int HOLD_LEN    = 400;
   localparam int SETTLE      = 20;
   localparam int DRAIN_MAX   = 100000;
   localparam int RAND_ITEMS  = 140;
   localparam int PHASE_ITEMS = 30;

   typedef struct packed {
      logic [STRIP_W-1:0]  strip;
      logic [PIXEL_W-1:0]  pixel;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } strip_item_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]   pixel;
      logic [CHANNEL_W-1:0] channel;
      logic [PLANE_W-1:0]   plane;
      logic [WORD_W-1:0]    word;
      logic                 last;
   } plane_out_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [STRIP_W-1:0]     req_strip = '0;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic [COLOUR_W-1:0]    req_red = '0;
   logic [COLOUR_W-1:0]    req_green = '0;
   logic [COLOUR_W-1:0]    req_blue = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_out_pixel;
   logic [CHANNEL_W-1:0]   rsp_channel;
   logic [PLANE_W-1:0]     rsp_plane;
   logic [WORD_W-1:0]      rsp_plane_word;
   logic                   rsp_last;

   strip_item_type req_backlog[$];
   plane_out_type  planes_due[$];

   logic [WORD_W-1:0]       plane_acc[STORE_WORDS];
   logic [PIXEL_W-1:0]      acc_pixel;
   logic [STRIPS_CFG_W-1:0] strips_reg;
   logic [PIXELS_CFG_W-1:0] pixels_reg;

   int   items_pushed = 0;
   int   items_taken = 0;
   int   csr_count = 0;
   int   errors = 0;
   int   cycle_count = 0;
   int   send_gap = 0;
   int   recv_gap = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   bit   idle_on = 1'b1;
   bit   quiet = 1'b0;
   logic req_fire = 1'b0;

   led_strip_bit_plane_transpose_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_strip      (req_strip),
      .req_pixel      (req_pixel),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_channel    (rsp_channel),
      .rsp_plane      (rsp_plane),
      .rsp_plane_word (rsp_plane_word),
      .rsp_last       (rsp_last)
   );

   always #10 clock = ~clock;

   task automatic report(input string msg);
      if (errors < 100) begin
         $display("mismatch: %s", msg);
      end
      errors++;
   endtask

   function automatic void clear_planes();
      for (int k = 0; k < STORE_WORDS; k++) begin
         plane_acc[k] = '0;
      end
   endfunction

   function automatic void fold_colour(input logic [CHANNEL_W-1:0] ch,
                                       input logic [COLOUR_W-1:0] value,
                                       input logic [WORD_W-1:0] mask);
      for (int b = 0; b < COLOUR_PLANES; b++) begin
         if (value[b]) begin
            plane_acc[ch * COLOUR_PLANES + COLOUR_PLANES - 1 - b] |= mask;
         end
      end
   endfunction

   task automatic transpose_item(input strip_item_type it);
      int             es;
      int             ep;
      plane_out_type  po;
      es = (strips_reg > MAX_STRIPS) ? MAX_STRIPS : strips_reg;
      ep = (pixels_reg > MAX_PIXELS) ? MAX_PIXELS : pixels_reg;
      if (it.strip >= es || it.pixel >= ep) begin
         return;
      end
      if (it.pixel != acc_pixel) begin
         clear_planes();
         acc_pixel = it.pixel;
      end
      fold_colour(CH_GREEN, it.green, WORD_W'(1) << it.strip);
      fold_colour(CH_RED, it.red, WORD_W'(1) << it.strip);
      fold_colour(CH_BLUE, it.blue, WORD_W'(1) << it.strip);
      if (it.strip == es - 1) begin
         for (int k = 0; k < STORE_WORDS; k++) begin
            po.pixel   = acc_pixel;
            po.channel = CHANNEL_W'(k / COLOUR_PLANES);
            po.plane   = PLANE_W'(k % COLOUR_PLANES);
            po.word    = plane_acc[k];
            po.last    = (k == STORE_WORDS - 1);
            planes_due.push_back(po);
         end
         clear_planes();
      end
   endtask

   task automatic check_word();
      plane_out_type want;
      if (planes_due.size() == 0) begin
         report($sformatf("unexpected word pixel %0d word %h", rsp_out_pixel, rsp_plane_word));
         return;
      end
      want = planes_due.pop_front();
      if (rsp_out_pixel !== want.pixel)
         report($sformatf("out_pixel %h, want %h", rsp_out_pixel, want.pixel));
      if (rsp_channel !== want.channel)
         report($sformatf("channel %h, want %h", rsp_channel, want.channel));
      if (rsp_plane !== want.plane)
         report($sformatf("plane %h, want %h", rsp_plane, want.plane));
      if (rsp_plane_word !== want.word)
         report($sformatf("plane_word %h, want %h (pixel %0d ch %0d plane %0d)",
                          rsp_plane_word, want.word, want.pixel, want.channel, want.plane));
      if (rsp_last !== want.last)
         report($sformatf("last %b, want %b", rsp_last, want.last));
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         clear_planes();
         acc_pixel  = '0;
         strips_reg = STRIPS_CFG_W'(MAX_STRIPS);
         pixels_reg = PIXELS_CFG_W'(MAX_PIXELS);
         req_fire  <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ACTIVE_STRIPS) begin
               strips_reg = csr_data[STRIPS_CFG_W-1:0];
            end else if (csr_index == CSR_ACTIVE_PIXELS) begin
               pixels_reg = csr_data[PIXELS_CFG_W-1:0];
            end
            csr_count <= csr_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            check_word();
         end
         if (req_valid && req_ready) begin
            transpose_item('{req_strip, req_pixel, req_red, req_green, req_blue});
            items_taken <= items_taken + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      strip_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (idle_on && !quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            req_valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            it = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_strip <= it.strip;
            req_pixel <= it.pixel;
            req_red   <= it.red;
            req_green <= it.green;
            req_blue  <= it.blue;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [COLOUR_W-1:0] rand_colour();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return COLOUR_W'($urandom);
      endcase
   endfunction

   task automatic queue_item(input int s, input int p, input logic [COLOUR_W-1:0] r,
                             input logic [COLOUR_W-1:0] g, input logic [COLOUR_W-1:0] b);
      req_backlog.push_back('{STRIP_W'(s), PIXEL_W'(p), r, g, b});
      items_pushed++;
   endtask

   task automatic queue_rand(input int s, input int p);
      queue_item(s, p, rand_colour(), rand_colour(), rand_colour());
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      int seen;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      seen = csr_count;
      do @(negedge clock); while (csr_count == seen);
      csr_valid <= 1'b0;
   endtask

   task automatic await_drain();
      int n;
      n = 0;
      while ((items_taken != items_pushed || planes_due.size() != 0) && n < DRAIN_MAX) begin
         @(negedge clock);
         n++;
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      int                      budget;
      int                      n;
      int                      es;
      int                      ep;
      int                      p;
      int                      len;
      int                      ph;
      logic [STRIPS_CFG_W-1:0] s5;
      logic [PIXELS_CFG_W-1:0] p7;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: pixel change from zero, extremes of every field
      queue_item(MAX_STRIPS - 1, MAX_PIXELS - 1, '1, '1, '1);
      queue_item(0, 0, '0, '0, '0);
      queue_item(MAX_STRIPS - 1, 0, 8'hAA, 8'h55, 8'hF0);
      await_drain();

      csr_write(CSR_ACTIVE_STRIPS, 8'd3);
      csr_write(CSR_ACTIVE_PIXELS, 8'd2);
      queue_rand(0, 1);
      queue_rand(1, 1);
      queue_rand(1, 1);
      queue_rand(2, 1);
      queue_rand(3, 0);
      queue_rand(0, 2);
      queue_rand(0, 0);
      queue_rand(1, 1);
      queue_rand(2, 1);
      queue_rand(1, 0);
      queue_rand(0, 0);
      queue_rand(2, 0);
      await_drain();

      csr_write(CSR_ACTIVE_STRIPS, 8'd1);
      csr_write(CSR_ACTIVE_PIXELS, 8'd100);
      queue_rand(0, MAX_PIXELS - 1);
      queue_rand(5, MAX_PIXELS - 1);
      queue_rand(0, 5);
      await_drain();

      csr_write(CSR_ACTIVE_STRIPS, 8'hFF);
      csr_write(CSR_ACTIVE_PIXELS, 8'd0);
      queue_rand(MAX_STRIPS - 1, 0);
      await_drain();

      csr_write(CSR_ACTIVE_STRIPS, 8'd0);
      csr_write(CSR_ACTIVE_PIXELS, 8'hFF);
      csr_write(CSR_INDEX_W'(2 ** CSR_INDEX_W - 1), 8'd1);
      queue_rand(0, 0);
      queue_rand(MAX_STRIPS - 1, MAX_PIXELS - 1);
      await_drain();

      csr_write(CSR_ACTIVE_STRIPS, 8'd16);
      csr_write(CSR_INDEX_W'($urandom_range(CSR_ACTIVE_PIXELS + 1, 2 ** CSR_INDEX_W - 1)),
                8'd0);
      queue_rand(MAX_STRIPS - 1, 10);
      await_drain();

      budget = RAND_ITEMS;
      ph = 0;
      while (budget > 0) begin
         if (ph == 0) begin
            s5 = 5'd4;
            p7 = 7'd64;
         end else begin
            case ($urandom_range(0, 5))
               0: s5 = 5'd1;
               1: s5 = 5'd16;
               2: s5 = STRIPS_CFG_W'($urandom_range(17, 31));
               default: s5 = STRIPS_CFG_W'($urandom_range(2, 15));
            endcase
            case ($urandom_range(0, 4))
               0: p7 = 7'd64;
               1: p7 = 7'd1;
               2: p7 = PIXELS_CFG_W'($urandom_range(65, 127));
               default: p7 = PIXELS_CFG_W'($urandom_range(2, 63));
            endcase
         end
         es = (s5 > MAX_STRIPS) ? MAX_STRIPS : s5;
         ep = (p7 > MAX_PIXELS) ? MAX_PIXELS : p7;
         csr_write(CSR_ACTIVE_STRIPS, {3'($urandom_range(0, 7)), s5});
         csr_write(CSR_ACTIVE_PIXELS, {1'($urandom_range(0, 1)), p7});
         if ($urandom_range(0, 2) == 0) begin
            csr_write(CSR_INDEX_W'($urandom_range(CSR_ACTIVE_PIXELS + 1, 2 ** CSR_INDEX_W - 1)),
                      CSR_DATA_W'($urandom));
         end
         idle_on = (ph % 3 != 2);
         if (budget <= PHASE_ITEMS) begin
            quiet = 1'b1;
         end

         n = 0;
         while (n < PHASE_ITEMS && n < budget) begin
            if ($urandom_range(0, 4) != 0) begin
               p = $urandom_range(0, ep - 1);
               len = es;
               if (es > 1 && $urandom_range(0, 7) == 0) begin
                  len = $urandom_range(1, es - 1);
               end
               for (int k = 0; k < len; k++) begin
                  if (k == es - 1 && es > 1 && $urandom_range(0, 5) == 0) begin
                     queue_rand($urandom_range(0, es - 2), p);
                     n++;
                  end
                  queue_rand(k, p);
                  n++;
               end
            end else begin
               p = $urandom_range(0, MAX_PIXELS - 1);
               len = $urandom_range(0, MAX_STRIPS - 1);
               queue_rand(len, p);
               if (len < es && p < ep) begin
                  n++;
               end
            end
         end
         budget -= n;
         await_drain();
         ph++;
      end

      if (planes_due.size() != 0) begin
         report($sformatf("%0d plane words never arrived", planes_due.size()));
      end
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### sim.f
sv/lbpt_pkg.sv
sv/lbpt_front.sv
sv/lbpt_queue.sv
sv/lbpt_back.sv
sv/led_strip_bit_plane_transpose_unit.sv
test/tb_top.sv
